// ----- hw/rtl/lzwd_pkg.sv -----
// ----------------------------------------------------------------------------
// lzwd_pkg
// Shared constants for the LZW variable width decoder.
// ----------------------------------------------------------------------------
package lzwd_pkg;

  localparam logic [12:0] CODE_CLEAR = 13'd256;
  localparam logic [12:0] CODE_END   = 13'd257;
  localparam logic [12:0] CODE_FIRST = 13'd258;
  localparam logic [3:0]  MIN_WIDTH  = 4'd9;

  localparam logic [2:0] ST_RUN      = 3'd0;
  localparam logic [2:0] ST_DONE     = 3'd1;
  localparam logic [2:0] ST_BAD_CODE = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_NO_END   = 3'd4;
  localparam logic [2:0] ST_MISMATCH = 3'd5;

  localparam logic KIND_FEED = 1'b0;
  localparam logic KIND_PULL = 1'b1;

  localparam int STACK_BITS = 12;

endpackage

// ----- hw/rtl/lzwd_if.sv -----
// ----------------------------------------------------------------------------
// lzwd_in_if / lzwd_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface lzwd_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_in;
  logic       last_byte;
  modport source (output valid, kind, data_in, last_byte, input ready);
  modport sink (input valid, kind, data_in, last_byte, output ready);
endinterface

interface lzwd_out_if #(parameter int LENGTH_BITS = 24);
  logic                   valid;
  logic                   ready;
  logic                   accepted;
  logic                   data_valid;
  logic [7:0]             data_out;
  logic [2:0]             status;
  logic [LENGTH_BITS-1:0] produced_count;
  modport source (output valid, accepted, data_valid, data_out, status, produced_count,
    input ready);
  modport sink (input valid, accepted, data_valid, data_out, status, produced_count,
    output ready);
endinterface

// ----- hw/rtl/lzw_variable_width_decoder.sv -----
// ----------------------------------------------------------------------------
// lzw_variable_width_decoder
// Streaming TIFF-style LZW decoder with 9..12 bit early-change codes.
// ----------------------------------------------------------------------------
// One item is handled at a time, and the input side stays not ready while a
// result waits to be taken. A pull with bytes on the stack reads the stack
// memory, then sets the result register. A feed that is refused, ignored,
// cuts no code, or cuts the end code or a bad code, and a pull on an empty
// stack, pass through S_RES and S_WAIT; a clear code passes S_FIN first. A
// feed that cuts a string code walks the prefix chain through the dictionary
// memory, reading each chain entry (S_RD), then pushing it (S_WALK), and
// ends through S_FIN, S_RES and S_WAIT. The next item is accepted no earlier
// than the cycle after the result is taken.
module lzw_variable_width_decoder #(
  parameter int MAX_CODE_BITS = 12,
  parameter int LENGTH_BITS   = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  lzwd_in_if.sink                in_ch,
  lzwd_out_if.source             out_ch,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [1:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int TDEPTH = 1 << MAX_CODE_BITS;
  localparam int SB = lzwd_pkg::STACK_BITS;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PULL  = 7'b0000010,
    S_RD    = 7'b0000100,
    S_WALK  = 7'b0001000,
    S_FIN   = 7'b0010000,
    S_RES   = 7'b0100000,
    S_WAIT  = 7'b1000000
  } state_t;

  state_t state;

  // dictionary and stack memories
  logic [11:0] prefix_mem [TDEPTH];
  logic [7:0]  suffix_mem [TDEPTH];
  logic [7:0]  stack_mem  [1 << SB];

  logic [LENGTH_BITS-1:0] expected_length;
  logic [SB:0]   stack_fill;
  logic [18:0]   bit_buffer;
  logic [4:0]    bit_fill;
  logic [3:0]    code_width;
  logic [12:0]   next_free;
  logic [11:0]   previous_code;
  logic          previous_valid;
  logic [7:0]    prior_first;
  logic [LENGTH_BITS-1:0] output_total;
  logic          end_seen;
  logic [2:0]    run_status;

  // walk state
  logic [11:0]   cur;
  logic [11:0]   code;
  logic [SB:0]   n;
  logic [11:0]   rd_prefix;
  logic [7:0]    rd_suffix;
  logic [7:0]    rd_stack;
  logic          last_r;

  // result register
  logic          r_acc, r_dv;
  logic [7:0]    r_dout;
  logic          res_pending;

  // apb
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr == 2'd0) prdata[LENGTH_BITS-1:0] = expected_length;
  end

  // feed path: combined bit buffer and code cut
  logic [18:0] buf_ins;
  logic [4:0]  fill_ins;
  logic [4:0]  sh;
  logic [18:0] cut_mask;
  logic [11:0] cut_code;
  logic        cut;
  always_comb begin
    buf_ins  = {bit_buffer[10:0], in_ch.data_in};
    fill_ins = bit_fill + 5'd8;
    cut      = fill_ins >= {1'b0, code_width};
    sh       = fill_ins - {1'b0, code_width};
    cut_mask = (19'd1 << code_width) - 19'd1;
    cut_code = 12'((buf_ins >> sh) & cut_mask);
  end

  assign in_ch.ready = (state == S_IDLE) && !res_pending;

  always_ff @(posedge clk) begin
    rd_prefix <= prefix_mem[cur];
    rd_suffix <= suffix_mem[cur];
    rd_stack  <= stack_mem[stack_fill[SB-1:0] - 1'b1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      expected_length <= LENGTH_BITS'(1);
      stack_fill <= '0;
      bit_buffer <= '0;
      bit_fill <= '0;
      code_width <= lzwd_pkg::MIN_WIDTH;
      next_free <= lzwd_pkg::CODE_FIRST;
      previous_code <= '0;
      previous_valid <= 1'b0;
      prior_first <= '0;
      output_total <= '0;
      end_seen <= 1'b0;
      run_status <= lzwd_pkg::ST_RUN;
      res_pending <= 1'b0;
      r_acc <= 1'b0;
      r_dv <= 1'b0;
      r_dout <= '0;
      last_r <= 1'b0;
      cur <= '0;
      code <= '0;
      n <= '0;
    end else begin
      if (psel && penable && pwrite && paddr == 2'd0)
        expected_length <= pwdata[LENGTH_BITS-1:0];
      if (res_pending && out_ch.ready) res_pending <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_ch.valid && !res_pending) begin
            r_dv <= 1'b0;
            r_dout <= '0;
            r_acc <= (in_ch.kind == lzwd_pkg::KIND_FEED) && (stack_fill == '0);
            last_r <= in_ch.last_byte;
            if (in_ch.kind == lzwd_pkg::KIND_PULL) begin
              state <= (stack_fill != '0) ? S_PULL : S_RES;
            end else if (stack_fill != '0 || run_status != lzwd_pkg::ST_RUN ||
                         end_seen) begin
              state <= S_RES;
            end else if (!cut) begin
              bit_fill <= fill_ins;
              bit_buffer <= buf_ins;
              if (in_ch.last_byte) run_status <= lzwd_pkg::ST_NO_END;
              state <= S_RES;
            end else begin
              bit_fill <= sh;
              bit_buffer <= buf_ins & ((19'd1 << sh) - 19'd1);
              code <= cut_code;
              if ({1'b0, cut_code} == lzwd_pkg::CODE_CLEAR) begin
                code_width <= lzwd_pkg::MIN_WIDTH;
                next_free <= lzwd_pkg::CODE_FIRST;
                previous_valid <= 1'b0;
                state <= S_FIN;
              end else if ({1'b0, cut_code} == lzwd_pkg::CODE_END) begin
                end_seen <= 1'b1;
                run_status <= (output_total == expected_length) ?
                  lzwd_pkg::ST_DONE : lzwd_pkg::ST_MISMATCH;
                state <= S_RES;
              end else if ({1'b0, cut_code} > next_free ||
                           32'(cut_code) >= TDEPTH) begin
                run_status <= lzwd_pkg::ST_BAD_CODE;
                state <= S_RES;
              end else if ({1'b0, cut_code} == next_free) begin
                if (!previous_valid) begin
                  run_status <= lzwd_pkg::ST_BAD_CODE;
                  state <= S_RES;
                end else begin
                  stack_mem[0] <= prior_first;
                  n <= (SB+1)'(1);
                  cur <= previous_code;
                  state <= S_RD;
                end
              end else begin
                n <= '0;
                cur <= cut_code;
                state <= S_RD;
              end
            end
          end
        end
        S_PULL: begin
          stack_fill <= stack_fill - 1'b1;
          r_dv <= 1'b1;
          r_dout <= rd_stack;
          res_pending <= 1'b1;
          state <= S_IDLE;
        end
        S_RD: begin
          // check chain entry; memory read address is cur
          if (cur < 12'd256) begin
            if (n[SB]) begin
              run_status <= lzwd_pkg::ST_BAD_CODE;
              state <= S_RES;
            end else begin
              stack_mem[n[SB-1:0]] <= cur[7:0];
              n <= n + 1'b1;
              state <= S_FIN;
            end
          end else if (n[SB]) begin
            run_status <= lzwd_pkg::ST_BAD_CODE;
            state <= S_RES;
          end else begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          stack_mem[n[SB-1:0]] <= rd_suffix;
          n <= n + 1'b1;
          cur <= rd_prefix;
          state <= S_RD;
        end
        S_FIN: begin
          state <= S_RES;
          if ({1'b0, code} != lzwd_pkg::CODE_CLEAR) begin
            if (33'(output_total) + 33'(n) > 33'(expected_length)) begin
              run_status <= lzwd_pkg::ST_OVERFLOW;
            end else begin
              logic [12:0] nf;
              nf = next_free;
              stack_fill <= n;
              output_total <= output_total + LENGTH_BITS'(n);
              if (previous_valid && 32'(next_free) < TDEPTH) begin
                prefix_mem[next_free[MAX_CODE_BITS-1:0]] <= previous_code;
                suffix_mem[next_free[MAX_CODE_BITS-1:0]] <= cur[7:0];
                nf = next_free + 13'd1;
              end
              next_free <= nf;
              previous_code <= code;
              previous_valid <= 1'b1;
              prior_first <= cur[7:0];
              if (32'(code_width) < MAX_CODE_BITS &&
                  32'(nf) + 1 >= (32'd1 << code_width))
                code_width <= code_width + 4'd1;
            end
          end
        end
        S_RES: begin
          if (r_acc && last_r && run_status == lzwd_pkg::ST_RUN && !end_seen)
            run_status <= lzwd_pkg::ST_NO_END;
          last_r <= 1'b0;
          state <= S_WAIT;
        end
        S_WAIT: begin
          res_pending <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid          = res_pending;
  assign out_ch.accepted       = r_acc;
  assign out_ch.data_valid     = r_dv;
  assign out_ch.data_out       = r_dout;
  assign out_ch.status         = run_status;
  assign out_ch.produced_count = output_total;

endmodule

// ----- tb/lzw_variable_width_decoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzw_variable_width_decoder_tb
// Encodes byte segments into one TIFF-style LZW stream (clear codes,
// repeated-byte runs, a high-entropy run) and feeds it to the decoder.
// It pulls decoded bytes and sends stray feeds and pulls. Every result is
// checked against a cycle-free predictor of the decoder. The stream ends
// with one randomly chosen finish: clean end, length mismatch, overflow,
// bad code or missing end code. Later feeds must then be ignored.
// ----------------------------------------------------------------------------
module lzw_variable_width_decoder_tb;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int TABLE_SIZE     = 4096;

  typedef struct packed {
    logic        accepted;
    logic        data_valid;
    logic [7:0]  data_out;
    logic [2:0]  status;
    logic [23:0] produced_count;
  } lzw_result_t;

  typedef enum {FINISH_CLEAN, FINISH_MISMATCH, FINISH_OVERFLOW, FINISH_BAD_CODE,
                FINISH_NO_END} finish_kind_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lzwd_in_if in_ch ();
  lzwd_out_if #(.LENGTH_BITS(24)) out_ch ();

  lzw_variable_width_decoder uut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // decoder state mirror
  logic [11:0] dict_prefix [TABLE_SIZE];
  logic [7:0]  dict_suffix [TABLE_SIZE];
  logic [7:0]  pend_bytes [TABLE_SIZE];
  logic [12:0] pend_fill;
  logic [18:0] acc_bits;
  logic [4:0]  acc_fill;
  logic [3:0]  cur_width;
  logic [12:0] free_code;
  logic [11:0] last_code;
  logic        last_ok;
  logic [7:0]  last_first;
  logic [23:0] total_out;
  logic        end_flag;
  logic [2:0]  dec_status;
  logic [23:0] target_len;

  lzw_result_t expected_q [$];
  int          code_list [$];
  logic [7:0]  stream_bytes [$];
  int          plan_total;
  int          dir_codes;
  int          dir_bytes;
  int          errors;
  int          items_sent;
  bit          quiet_run;
  int          stall_left;
  int          idle_cycles;

  // clock and watchdog
  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("lzw_variable_width_decoder verification failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet_run) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // expand one code into the pending stack, as the decoder does
  function automatic void decode_code(int code);
    int cur;
    int n;
    logic [7:0] first;
    n = 0;
    if (code == lzwd_pkg::CODE_CLEAR) begin
      cur_width = lzwd_pkg::MIN_WIDTH;
      free_code = lzwd_pkg::CODE_FIRST;
      last_ok = 1'b0;
      return;
    end
    if (code == lzwd_pkg::CODE_END) begin
      end_flag = 1'b1;
      dec_status = (total_out == target_len) ? lzwd_pkg::ST_DONE : lzwd_pkg::ST_MISMATCH;
      return;
    end
    if (code > free_code || code >= TABLE_SIZE) begin
      dec_status = lzwd_pkg::ST_BAD_CODE;
      return;
    end
    cur = code;
    if (cur == free_code) begin
      if (!last_ok) begin
        dec_status = lzwd_pkg::ST_BAD_CODE;
        return;
      end
      pend_bytes[n[11:0]] = last_first;
      n++;
      cur = int'(last_code);
    end
    while (cur >= lzwd_pkg::CODE_CLEAR) begin
      if (n >= TABLE_SIZE) begin
        dec_status = lzwd_pkg::ST_BAD_CODE;
        return;
      end
      pend_bytes[n[11:0]] = dict_suffix[cur[11:0]];
      n++;
      cur = int'(dict_prefix[cur[11:0]]);
    end
    if (n >= TABLE_SIZE) begin
      dec_status = lzwd_pkg::ST_BAD_CODE;
      return;
    end
    first = cur[7:0];
    pend_bytes[n[11:0]] = first;
    n++;
    if (longint'(total_out) + n > longint'(target_len)) begin
      dec_status = lzwd_pkg::ST_OVERFLOW;
      return;
    end
    pend_fill = 13'(n);
    total_out = total_out + 24'(n);
    if (last_ok && free_code < TABLE_SIZE) begin
      dict_prefix[free_code[11:0]] = last_code;
      dict_suffix[free_code[11:0]] = first;
      free_code++;
    end
    last_code = 12'(code);
    last_ok = 1'b1;
    last_first = first;
    if (cur_width < 12 && (int'(free_code) + 1) >= (1 << cur_width))
      cur_width++;
  endfunction

  function automatic lzw_result_t predict_item(logic kind, logic [7:0] data, logic last);
    lzw_result_t res;
    int sh;
    int code;
    res = '0;
    if (kind == lzwd_pkg::KIND_FEED) begin
      if (pend_fill == 0) begin
        res.accepted = 1'b1;
        if (dec_status == lzwd_pkg::ST_RUN && !end_flag) begin
          acc_bits = {acc_bits[10:0], data};
          acc_fill = acc_fill + 5'd8;
          if (acc_fill >= {1'b0, cur_width}) begin
            sh = int'(acc_fill) - int'(cur_width);
            code = (int'(acc_bits) >> sh) & ((1 << cur_width) - 1);
            acc_fill = 5'(sh);
            acc_bits = 19'(int'(acc_bits) & ((1 << sh) - 1));
            decode_code(code);
          end
          if (last && dec_status == lzwd_pkg::ST_RUN && !end_flag)
            dec_status = lzwd_pkg::ST_NO_END;
        end
      end
    end else if (pend_fill > 0) begin
      pend_fill--;
      res.data_valid = 1'b1;
      res.data_out = pend_bytes[pend_fill[11:0]];
    end
    res.status = dec_status;
    res.produced_count = total_out;
    return res;
  endfunction

  // result checker
  always @(posedge clk) begin : check_result
    lzw_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result acc=%0b dv=%0b dout=%02h st=%0d cnt=%0d", $time,
                 out_ch.accepted, out_ch.data_valid, out_ch.data_out, out_ch.status,
                 out_ch.produced_count);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (out_ch.accepted !== want.accepted || out_ch.data_valid !== want.data_valid ||
            out_ch.data_out !== want.data_out || out_ch.status !== want.status ||
            out_ch.produced_count !== want.produced_count) begin
          $display("%0t: expected acc=%0b dv=%0b dout=%02h st=%0d cnt=%0d", $time,
                   want.accepted, want.data_valid, want.data_out, want.status,
                   want.produced_count);
          $display("%0t: actual   acc=%0b dv=%0b dout=%02h st=%0d cnt=%0d", $time,
                   out_ch.accepted, out_ch.data_valid, out_ch.data_out, out_ch.status,
                   out_ch.produced_count);
          errors++;
        end
      end
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  task automatic send_item(input logic kind, input logic [7:0] data, input logic last);
    int gap;
    if (items_sent % 200 == 0) quiet_run = ($urandom_range(0, 2) == 0);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.data_in <= data;
    in_ch.last_byte <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_q.push_back(predict_item(kind, data, last));
  endtask

  task automatic send_pull();
    send_item(lzwd_pkg::KIND_PULL, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic apb_write(input logic [23:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 2'd0;
    pwdata <= {8'h00, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    target_len = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // lzw encoder for one segment, opened by a clear code
  task automatic encode_segment(input logic [7:0] seg [$]);
    int enc_dict [int];
    int enc_free;
    int cur;
    int key;
    code_list.push_back(int'(lzwd_pkg::CODE_CLEAR));
    enc_free = int'(lzwd_pkg::CODE_FIRST);
    cur = seg[0];
    for (int i = 1; i < seg.size(); i++) begin
      key = cur * 256 + seg[i];
      if (enc_dict.exists(key)) begin
        cur = enc_dict[key];
      end else begin
        code_list.push_back(cur);
        if (enc_free < TABLE_SIZE) begin
          enc_dict[key] = enc_free;
          enc_free++;
        end
        cur = seg[i];
      end
    end
    code_list.push_back(cur);
    plan_total += seg.size();
  endtask

  task automatic random_segment(input int len, input bit full_alphabet);
    logic [7:0] seg [$];
    logic [7:0] sym [4];
    int nsym;
    nsym = $urandom_range(1, 4);
    foreach (sym[i]) sym[i] = 8'($urandom_range(0, 255));
    for (int i = 0; i < len; i++)
      seg.push_back(full_alphabet ? 8'($urandom_range(0, 255)) :
                                    sym[$urandom_range(0, nsym - 1)]);
    encode_segment(seg);
  endtask

  // pack codes msb first at the width the decoder will be using
  task automatic pack_stream();
    int w;
    int nf;
    bit pv;
    bit bits [$];
    logic [7:0] b;
    w = 9;
    nf = int'(lzwd_pkg::CODE_FIRST);
    pv = 0;
    dir_bytes = 0;
    foreach (code_list[i]) begin
      for (int k = w - 1; k >= 0; k--) bits.push_back(1'((code_list[i] >> k) & 1));
      if (code_list[i] == lzwd_pkg::CODE_CLEAR) begin
        w = 9;
        nf = int'(lzwd_pkg::CODE_FIRST);
        pv = 0;
      end else if (code_list[i] != lzwd_pkg::CODE_END) begin
        if (pv && nf < TABLE_SIZE) nf++;
        pv = 1;
        if (w < 12 && nf + 1 >= (1 << w)) w++;
      end
      if (i == dir_codes - 1) dir_bytes = bits.size() / 8;
    end
    while (bits.size() % 8 != 0) bits.push_back(0);
    for (int i = 0; i < bits.size(); i += 8) begin
      for (int k = 0; k < 8; k++) b[7 - k] = bits[i + k];
      stream_bytes.push_back(b);
    end
  endtask

  // feed a range of the stream, pulling whenever the stack holds bytes
  task automatic feed_range(input int lo, input int hi);
    for (int i = lo; i < hi; i++) begin
      while (pend_fill > 0) begin
        if ($urandom_range(0, 9) == 0)
          send_item(lzwd_pkg::KIND_FEED, 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
        else
          send_pull();
      end
      if ($urandom_range(0, 19) == 0) send_pull();
      send_item(lzwd_pkg::KIND_FEED, stream_bytes[i], i == stream_bytes.size() - 1);
    end
  endtask

  task automatic test_empty_pulls();
    send_item(lzwd_pkg::KIND_PULL, 8'hFF, 1'b1);
    send_item(lzwd_pkg::KIND_PULL, 8'h00, 1'b0);
    send_item(lzwd_pkg::KIND_PULL, 8'hA5, 1'b1);
  endtask

  task automatic test_length_register(input finish_kind_t fin);
    wait_drained();
    apb_write(24'hFFFFFF);
    send_pull();
    wait_drained();
    apb_write(24'd1);
    send_pull();
    wait_drained();
    case (fin)
      FINISH_CLEAN:    apb_write(24'(plan_total));
      FINISH_MISMATCH: apb_write(($urandom_range(0, 1) == 0) ? 24'hFFFFFF :
                                 24'(plan_total + $urandom_range(1, 50)));
      FINISH_OVERFLOW: apb_write(24'($urandom_range(1, plan_total - 1)));
      default:         apb_write(24'hFFFFFF);
    endcase
  endtask

  task automatic test_directed_stream();
    feed_range(0, dir_bytes);
  endtask

  task automatic test_random_stream();
    feed_range(dir_bytes, stream_bytes.size());
  endtask

  task automatic test_after_finish();
    while (pend_fill > 0) send_pull();
    for (int i = 0; i < 12; i++) begin
      send_item(lzwd_pkg::KIND_FEED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      send_pull();
    end
    wait_drained();
  endtask

  initial begin : run
    finish_kind_t fin;
    logic [7:0] dir_seg [$];
    errors = 0;
    items_sent = 0;
    quiet_run = 0;
    stall_left = 0;
    idle_cycles = 0;
    plan_total = 0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 2'd0;
    pwdata = 32'd0;
    in_ch.valid = 1'b0;
    in_ch.kind = lzwd_pkg::KIND_PULL;
    in_ch.data_in = 8'd0;
    in_ch.last_byte = 1'b0;
    out_ch.ready = 1'b0;
    pend_fill = '0;
    acc_bits = '0;
    acc_fill = '0;
    cur_width = lzwd_pkg::MIN_WIDTH;
    free_code = lzwd_pkg::CODE_FIRST;
    last_code = '0;
    last_ok = 1'b0;
    last_first = '0;
    total_out = '0;
    end_flag = 1'b0;
    dec_status = lzwd_pkg::ST_RUN;
    target_len = 24'd1;

    // build the stream: directed part, random segments around a high-entropy run, finish
    dir_seg = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h61, 8'h61, 8'h61, 8'h61, 8'h61, 8'h61,
                8'h61, 8'h61, 8'h00, 8'h00};
    encode_segment(dir_seg);
    dir_codes = code_list.size();
    for (int s = 0; s < 3; s++) random_segment($urandom_range(20, 60), $urandom_range(0, 2) == 0);
    random_segment(100, 1'b1);
    random_segment($urandom_range(20, 40), 1'b0);
    fin = finish_kind_t'($urandom_range(0, 4));
    case (fin)
      FINISH_BAD_CODE: begin
        code_list.push_back(int'(lzwd_pkg::CODE_CLEAR));
        if ($urandom_range(0, 1) == 0) begin
          // string code equal to the next free entry with no previous code
          code_list.push_back(int'(lzwd_pkg::CODE_FIRST));
        end else begin
          // code beyond the next free entry
          code_list.push_back(8'h41);
          code_list.push_back(int'(lzwd_pkg::CODE_FIRST) + 2);
        end
        code_list.push_back(int'(lzwd_pkg::CODE_END));
      end
      FINISH_NO_END: ;
      default: code_list.push_back(int'(lzwd_pkg::CODE_END));
    endcase
    pack_stream();

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_pulls();
    test_length_register(fin);
    test_directed_stream();
    test_random_stream();
    test_after_finish();

    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("lzw_variable_width_decoder verification clean");
    else
      $display("lzw_variable_width_decoder verification failed");
    $finish;
  end

endmodule
